// ===== rtl/core/rwpg_pkg.sv =====
// ----------------------------------------------------------------------------
// rwpg_pkg
// Shared widths, register indexes, codes and types of the rolling wave
// pixel generator.
// ----------------------------------------------------------------------------
package rwpg_pkg;

  localparam int PATTERN_DEPTH = 16;
  localparam int SLOT_W        = 4;
  localparam int PIX_W         = 10;
  localparam int COLOR_W       = 24;
  localparam int CH_W          = 8;
  localparam int GRAD_W        = 8;
  localparam int LEN_W         = 9;
  localparam int PLEN_W        = 5;
  localparam int MODE_W        = 2;
  localparam int CC_W          = 13;
  localparam int CC_STEP_W     = 4;
  localparam int POS_W         = 14;
  localparam int DIV_W         = 16;
  localparam int DVS_W         = 9;
  localparam int DIV_STEPS     = DIV_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAIL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLEN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BG      = 3'd5;

  localparam logic [MODE_W-1:0] TRAIL_END  = 2'd0;
  localparam logic [MODE_W-1:0] TRAIL_BOTH = 2'd1;
  localparam logic [MODE_W-1:0] TRAIL_LEAD = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef struct packed {
    logic [GRAD_W-1:0]  grad;
    logic [GRAD_W-1:0]  spacing;
    logic [MODE_W-1:0]  trail_mode;
    logic [CH_W-1:0]    dim;
    logic [PLEN_W-1:0]  plen;
    logic [COLOR_W-1:0] bg;
    logic [LEN_W-1:0]   wave_len;
  } rwpg_cfg_t;

  typedef struct packed {
    logic            busy;
    logic [CC_W-1:0] ccn;
    logic [CC_W-1:0] total;
  } rwpg_cc_t;

  typedef struct packed {
    logic               pixel;
    logic [PIX_W-1:0]   index;
    logic [SLOT_W-1:0]  slot;
    logic [COLOR_W-1:0] color;
    logic [DVS_W-1:0]   rem;
    logic               head;
    logic               in_wave;
  } rwpg_side_t;

  typedef struct packed {
    logic [PIX_W-1:0] index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
  } rwpg_pix_t;

  function automatic logic [PLEN_W-1:0] used_len(input logic [PLEN_W-1:0] n);
    logic [PLEN_W-1:0] r;
    r = n;
    if (n == '0) begin
      r = PLEN_W'(1);
    end else if (n > PLEN_W'(PATTERN_DEPTH)) begin
      r = PLEN_W'(PATTERN_DEPTH);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/rwpg_if.sv =====
// ----------------------------------------------------------------------------
// rwpg_if
// Valid/ready stream channels for pixel and pattern-load requests and drawn pixels.
// ----------------------------------------------------------------------------
interface rwpg_in_if;
  import rwpg_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic [PIX_W-1:0]   pixel_index;
  logic               last_pixel;
  logic [SLOT_W-1:0]  entry_index;
  logic [COLOR_W-1:0] entry_color;

  modport source (
    output valid, op, pixel_index, last_pixel, entry_index, entry_color,
    input  ready
  );
  modport sink (
    input  valid, op, pixel_index, last_pixel, entry_index, entry_color,
    output ready
  );
endinterface

interface rwpg_out_if;
  import rwpg_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_index;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;

  modport source (
    output valid, out_index, red, green, blue,
    input  ready
  );
  modport sink (
    input  valid, out_index, red, green, blue,
    output ready
  );
endinterface

// ===== rtl/core/rwpg_div_pipe.sv =====
// ----------------------------------------------------------------------------
// rwpg_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// payload that travels alongside.
// ----------------------------------------------------------------------------
module rwpg_div_pipe (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [rwpg_pkg::DIV_W-1:0]   in_dividend,
  input  logic [rwpg_pkg::DVS_W-1:0]   in_divisor,
  input  rwpg_pkg::rwpg_side_t         in_side,
  output logic                         out_valid,
  output logic [rwpg_pkg::DIV_W-1:0]   out_quot,
  output logic [rwpg_pkg::DVS_W-1:0]   out_rem,
  output rwpg_pkg::rwpg_side_t         out_side
);
  import rwpg_pkg::*;

  logic [DIV_STEPS-1:0] v_r;
  logic [DVS_W-1:0]     rem_r  [DIV_STEPS];
  logic [DIV_W-1:0]     num_r  [DIV_STEPS];
  logic [DVS_W-1:0]     dvs_r  [DIV_STEPS];
  rwpg_side_t           side_r [DIV_STEPS];

  logic [DIV_STEPS-1:0] vi;
  logic [DVS_W-1:0]     ri    [DIV_STEPS];
  logic [DIV_W-1:0]     ni    [DIV_STEPS];
  logic [DVS_W-1:0]     di    [DIV_STEPS];
  rwpg_side_t           si    [DIV_STEPS];
  logic [DVS_W:0]       trial [DIV_STEPS];
  logic [DVS_W:0]       diff  [DIV_STEPS];
  logic [DIV_STEPS-1:0] ge;

  always_comb begin
    vi[0] = in_valid;
    ri[0] = '0;
    ni[0] = in_dividend;
    di[0] = in_divisor;
    si[0] = in_side;
    for (int k = 1; k < DIV_STEPS; k++) begin
      vi[k] = v_r[k-1];
      ri[k] = rem_r[k-1];
      ni[k] = num_r[k-1];
      di[k] = dvs_r[k-1];
      si[k] = side_r[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial[k] = {ri[k], ni[k][DIV_W-1]};
      ge[k]    = trial[k] >= {1'b0, di[k]};
      diff[k]  = trial[k] - {1'b0, di[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= vi;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_r[k]  <= ge[k] ? diff[k][DVS_W-1:0] : trial[k][DVS_W-1:0];
        num_r[k]  <= {ni[k][DIV_W-2:0], ge[k]};
        dvs_r[k]  <= di[k];
        side_r[k] <= si[k];
      end
    end
  end

  assign out_valid = v_r[DIV_STEPS-1];
  assign out_quot  = num_r[DIV_STEPS-1];
  assign out_rem   = rem_r[DIV_STEPS-1];
  assign out_side  = side_r[DIV_STEPS-1];

endmodule

// ===== rtl/core/rwpg_ctrl.sv =====
// ----------------------------------------------------------------------------
// rwpg_ctrl
// Configuration registers, frame cycle counter and the sequencer that
// reduces the cycle count modulo the pattern period after a geometry change.
// ----------------------------------------------------------------------------
module rwpg_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rwpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rwpg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            cc_step,
  output rwpg_pkg::rwpg_cfg_t             cfg,
  output rwpg_pkg::rwpg_cc_t              cc
);
  import rwpg_pkg::*;

  localparam logic [1:0] N_IDLE = 2'd0;
  localparam logic [1:0] N_MUL  = 2'd1;
  localparam logic [1:0] N_DIV  = 2'd2;

  localparam logic [GRAD_W-1:0] RST_GRAD    = 8'd4;
  localparam logic [GRAD_W-1:0] RST_SPACING = 8'd2;
  localparam logic [CH_W-1:0]   RST_DIM     = 8'd255;
  localparam logic [PLEN_W-1:0] RST_PLEN    = 5'd1;
  localparam logic [CC_W-1:0]   RST_TOTAL   =
    CC_W'(int'(RST_PLEN) * (int'(RST_GRAD) + int'(RST_SPACING)));

  logic [GRAD_W-1:0]    grad_r;
  logic [GRAD_W-1:0]    spacing_r;
  logic [MODE_W-1:0]    trail_r;
  logic [CH_W-1:0]      dim_r;
  logic [PLEN_W-1:0]    plen_r;
  logic [COLOR_W-1:0]   bg_r;

  logic [1:0]           state_r, state_nxt;
  logic [CC_STEP_W-1:0] step_r, step_nxt;
  logic [CC_W-1:0]      rem_r, rem_nxt;
  logic [CC_W-1:0]      total_r, total_nxt;
  logic [CC_W-1:0]      ccn_r, ccn_nxt;
  logic [CC_W-1:0]      cc_r, cc_nxt;

  logic                 start;
  logic [POS_W-1:0]     period;
  logic [CC_W:0]        trial;
  logic [CC_W:0]        diff;
  logic                 ge;
  logic [CC_W-1:0]      rem_step;
  logic [CC_W-1:0]      inc;

  assign cfg.grad       = grad_r;
  assign cfg.spacing    = spacing_r;
  assign cfg.trail_mode = trail_r;
  assign cfg.dim        = dim_r;
  assign cfg.plen       = used_len(plen_r);
  assign cfg.bg         = bg_r;
  assign cfg.wave_len   = {1'b0, grad_r} + {1'b0, spacing_r};

  assign cc.busy  = state_r != N_IDLE;
  assign cc.ccn   = ccn_r;
  assign cc.total = total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grad_r    <= RST_GRAD;
      spacing_r <= RST_SPACING;
      trail_r   <= TRAIL_BOTH;
      dim_r     <= RST_DIM;
      plen_r    <= RST_PLEN;
      bg_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRAD:    grad_r    <= cfg_data[GRAD_W-1:0];
        CFG_SPACING: spacing_r <= cfg_data[GRAD_W-1:0];
        CFG_TRAIL:   trail_r   <= cfg_data[MODE_W-1:0];
        CFG_DIM:     dim_r     <= cfg_data[CH_W-1:0];
        CFG_PLEN:    plen_r    <= cfg_data[PLEN_W-1:0];
        CFG_BG:      bg_r      <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign start = cfg_we && (cfg_index == CFG_GRAD || cfg_index == CFG_SPACING ||
                            cfg_index == CFG_PLEN);

  assign period   = POS_W'(cfg.plen) * POS_W'(cfg.wave_len);
  assign trial    = {rem_r, cc_r[step_r]};
  assign ge       = trial >= {1'b0, total_r};
  assign diff     = trial - {1'b0, total_r};
  assign rem_step = ge ? diff[CC_W-1:0] : trial[CC_W-1:0];
  assign inc      = ccn_r + CC_W'(1);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    total_nxt = total_r;
    ccn_nxt   = ccn_r;
    cc_nxt    = cc_r;
    unique case (state_r)
      N_IDLE: begin
        if (cc_step) begin
          if (total_r == '0 || inc == total_r) begin
            cc_nxt  = '0;
            ccn_nxt = '0;
          end else begin
            cc_nxt  = inc;
            ccn_nxt = inc;
          end
        end
      end
      N_MUL: begin
        total_nxt = period[CC_W-1:0];
        rem_nxt   = '0;
        step_nxt  = CC_STEP_W'(CC_W - 1);
        state_nxt = N_DIV;
      end
      N_DIV: begin
        rem_nxt = rem_step;
        if (step_r == '0) begin
          ccn_nxt   = rem_step;
          state_nxt = N_IDLE;
        end else begin
          step_nxt = step_r - CC_STEP_W'(1);
        end
      end
      default: state_nxt = N_IDLE;
    endcase
    if (start) begin
      state_nxt = N_MUL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      step_r  <= '0;
      rem_r   <= '0;
      total_r <= RST_TOTAL;
      ccn_r   <= '0;
      cc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      rem_r   <= rem_nxt;
      total_r <= total_nxt;
      ccn_r   <= ccn_nxt;
      cc_r    <= cc_nxt;
    end
  end

endmodule

// ===== rtl/core/rwpg_out_skid.sv =====
// ----------------------------------------------------------------------------
// rwpg_out_skid
// Output register with a skid entry; its registered ready drives the
// pipeline advance.
// ----------------------------------------------------------------------------
module rwpg_out_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  rwpg_pkg::rwpg_pix_t push_data,
  output logic                adv,
  rwpg_out_if.source          out_ch
);
  import rwpg_pkg::*;

  logic      main_v_r;
  rwpg_pix_t main_d_r;
  logic      skid_v_r;
  rwpg_pix_t skid_d_r;
  logic      push;
  logic      take;

  assign adv  = !skid_v_r;
  assign push = push_valid && adv;
  assign take = main_v_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        skid_v_r <= 1'b0;
      end
    end else if (!main_v_r || take) begin
      main_v_r <= push;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) begin
        main_d_r <= skid_d_r;
      end
    end else if (!main_v_r || take) begin
      main_d_r <= push_data;
    end else begin
      skid_d_r <= push_data;
    end
  end

  assign out_ch.valid     = main_v_r;
  assign out_ch.out_index = main_d_r.index;
  assign out_ch.red       = main_d_r.red;
  assign out_ch.green     = main_d_r.green;
  assign out_ch.blue      = main_d_r.blue;

endmodule

// ===== rtl/core/rolling_wave_pixel_generator_top.sv =====
// ----------------------------------------------------------------------------
// rolling_wave_pixel_generator_top
// Throughput: one transaction per cycle while the output does not stall and
// no count reduction runs; a pattern load gives no result. Reset (rst_n,
// synchronous): clears valid bits and cycle count, loads the registers with
// their reset values; the pattern table is not cleared. A write to grad_length,
// spacing or pattern_length holds off the input while the count is reduced.
// ----------------------------------------------------------------------------
module rolling_wave_pixel_generator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rwpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rwpg_pkg::CFG_DATA_W-1:0] cfg_data,
  rwpg_in_if.sink                         in_ch,
  rwpg_out_if.source                      out_ch
);
  import rwpg_pkg::*;

  rwpg_cfg_t          cfg;
  rwpg_cc_t           cc;
  logic               adv;
  logic               accept;
  logic               cc_step;

  logic               e_v_r;
  logic [POS_W-1:0]   e_pos_r;
  rwpg_side_t         e_side_r;
  rwpg_side_t         e_side_nxt;

  logic               d1_v;
  logic [DIV_W-1:0]   d1_quot;
  logic [DVS_W-1:0]   d1_rem;
  rwpg_side_t         d1_side;
  rwpg_side_t         d2_side_in;

  logic               d2_v;
  logic [DVS_W-1:0]   d2_rem;
  rwpg_side_t         d2_side;

  logic [COLOR_W-1:0] pat_mem [PATTERN_DEPTH];

  logic [GRAD_W-1:0]  half;
  logic [GRAD_W-1:0]  first;
  logic [GRAD_W-1:0]  mid;
  logic               adj;
  logic [DVS_W-1:0]   st_full;
  rwpg_side_t         t1_side_nxt;

  logic               t1_v_r;
  rwpg_side_t         t1_side_r;
  logic [COLOR_W-1:0] t1_wave_r;
  logic [GRAD_W-1:0]  t1_st_r;
  logic [GRAD_W-1:0]  t1_half_r;

  logic               t2_v_r;
  rwpg_side_t         t2_side_r;
  rwpg_side_t         t2_side_nxt;
  logic [DIV_W-1:0]   t2_prod_r;
  logic [DVS_W-1:0]   t2_dvs_r;

  logic               d3_v;
  logic [DIV_W-1:0]   d3_quot;
  rwpg_side_t         d3_side;

  logic               s_v_r;
  rwpg_side_t         s_side_r;
  logic [DVS_W-1:0]   s_scale_r;

  logic [16:0]        prod_red;
  logic [16:0]        prod_green;
  logic [16:0]        prod_blue;
  rwpg_pix_t          m_pix_nxt;
  logic               m_v_r;
  rwpg_pix_t          m_pix_r;

  rwpg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cc_step   (cc_step),
    .cfg       (cfg),
    .cc        (cc)
  );

  assign in_ch.ready = adv && !cc.busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cc_step     = accept && in_ch.op == OP_DRAW && in_ch.last_pixel;

  always_comb begin
    e_side_nxt         = '0;
    e_side_nxt.pixel   = in_ch.op == OP_DRAW;
    e_side_nxt.index   = in_ch.pixel_index;
    e_side_nxt.slot    = in_ch.entry_index;
    e_side_nxt.color   = in_ch.entry_color;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (adv) begin
      e_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_pos_r  <= POS_W'(cc.ccn) + POS_W'(in_ch.pixel_index);
      e_side_r <= e_side_nxt;
    end
  end

  rwpg_div_pipe u_div_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (e_v_r),
    .in_dividend (DIV_W'(e_pos_r)),
    .in_divisor  (cfg.wave_len),
    .in_side     (e_side_r),
    .out_valid   (d1_v),
    .out_quot    (d1_quot),
    .out_rem     (d1_rem),
    .out_side    (d1_side)
  );

  always_comb begin
    d2_side_in     = d1_side;
    d2_side_in.rem = d1_rem;
  end

  rwpg_div_pipe u_div_wave (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (d1_v),
    .in_dividend (d1_quot),
    .in_divisor  (DVS_W'(cfg.plen)),
    .in_side     (d2_side_in),
    .out_valid   (d2_v),
    .out_quot    (),
    .out_rem     (d2_rem),
    .out_side    (d2_side)
  );

  always_comb begin
    unique case (cfg.trail_mode)
      TRAIL_END: begin
        half  = cfg.grad;
        first = '0;
        adj   = 1'b0;
        mid   = '0;
      end
      TRAIL_LEAD: begin
        half  = cfg.grad;
        first = cfg.grad;
        adj   = 1'b0;
        mid   = cfg.grad - GRAD_W'(1);
      end
      default: begin
        half  = cfg.grad >> 1;
        first = cfg.grad >> 1;
        adj   = cfg.grad[0];
        mid   = cfg.grad >> 1;
      end
    endcase
    if (d2_side.rem < {1'b0, first}) begin
      st_full = {1'b0, half} - d2_side.rem;
    end else begin
      st_full = {1'b0, half} + DVS_W'(adj) + d2_side.rem - {1'b0, cfg.grad};
    end
    t1_side_nxt         = d2_side;
    t1_side_nxt.head    = d2_side.rem == {1'b0, mid};
    t1_side_nxt.in_wave = cfg.wave_len != '0 && d2_side.rem < {1'b0, cfg.grad};
  end

  always_ff @(posedge clk) begin
    if (adv && d2_v && !d2_side.pixel) begin
      pat_mem[d2_side.slot] <= d2_side.color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
      t2_v_r <= 1'b0;
      s_v_r  <= 1'b0;
      m_v_r  <= 1'b0;
    end else if (adv) begin
      t1_v_r <= d2_v;
      t2_v_r <= t1_v_r;
      s_v_r  <= d3_v;
      m_v_r  <= s_v_r && s_side_r.pixel;
    end
  end

  always_comb begin
    t2_side_nxt       = t1_side_r;
    t2_side_nxt.color = t1_wave_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_side_r <= t1_side_nxt;
      t1_wave_r <= pat_mem[d2_rem[SLOT_W-1:0]];
      t1_st_r   <= st_full[GRAD_W-1:0];
      t1_half_r <= half;

      t2_side_r <= t2_side_nxt;
      t2_prod_r <= DIV_W'(t1_st_r) * DIV_W'(cfg.dim);
      t2_dvs_r  <= {1'b0, t1_half_r} + DVS_W'(1);

      s_side_r  <= d3_side;
      s_scale_r <= {1'b0, cfg.dim} - {1'b0, d3_quot[CH_W-1:0]} + DVS_W'(1);

      m_pix_r <= m_pix_nxt;
    end
  end

  rwpg_div_pipe u_div_dim (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (t2_v_r),
    .in_dividend (t2_prod_r),
    .in_divisor  (t2_dvs_r),
    .in_side     (t2_side_r),
    .out_valid   (d3_v),
    .out_quot    (d3_quot),
    .out_rem     (),
    .out_side    (d3_side)
  );

  assign prod_red   = 17'(s_side_r.color[23:16]) * 17'(s_scale_r);
  assign prod_green = 17'(s_side_r.color[15:8]) * 17'(s_scale_r);
  assign prod_blue  = 17'(s_side_r.color[7:0]) * 17'(s_scale_r);

  always_comb begin
    m_pix_nxt.index = s_side_r.index;
    if (!s_side_r.in_wave) begin
      {m_pix_nxt.red, m_pix_nxt.green, m_pix_nxt.blue} = cfg.bg;
    end else if (s_side_r.head) begin
      {m_pix_nxt.red, m_pix_nxt.green, m_pix_nxt.blue} = s_side_r.color;
    end else begin
      m_pix_nxt.red   = prod_red[15:8];
      m_pix_nxt.green = prod_green[15:8];
      m_pix_nxt.blue  = prod_blue[15:8];
    end
  end

  rwpg_out_skid u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (m_v_r),
    .push_data  (m_pix_r),
    .adv        (adv),
    .out_ch     (out_ch)
  );

  a_ccn_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!cc.busy && cc.total != '0) |-> (cc.ccn < cc.total))
    else $error("reduced cycle count out of range");

  a_norm_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == CFG_GRAD || cfg_index == CFG_SPACING ||
                cfg_index == CFG_PLEN)) |=> cc.busy)
    else $error("geometry write did not start count reduction");

  a_skid_full: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |-> out_ch.valid)
    else $error("skid entry held with empty output register");

endmodule

// ===== verif/rolling_wave_pixel_generator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_wave_pixel_generator_top_tb
// Self-checking bench for the rolling wave pixel generator. It loads the
// color palette, draws pixels under directed and random register settings,
// and compares every drawn pixel against a local model of the wave, trail
// dimming and frame cycle count. Both stream sides idle at random, and one
// phase holds the output side off long enough to stall the input.
// ----------------------------------------------------------------------------
module rolling_wave_pixel_generator_top_tb;
  import rwpg_pkg::*;

  localparam int DRAIN_CYCLES = 64;
  localparam int RAND_PHASES  = 5;
  localparam int PHASE_ITEMS  = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rwpg_in_if  in_ch ();
  rwpg_out_if out_ch ();

  rolling_wave_pixel_generator_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // register and state mirror
  int unsigned      grad_m;
  int unsigned      spacing_m;
  logic [MODE_W-1:0] trail_m;
  int unsigned      dim_m;
  int unsigned      plen_m;
  int unsigned      bg_m;
  int unsigned      frame_cyc;
  logic [COLOR_W-1:0] palette [PATTERN_DEPTH];

  rwpg_pix_t pixel_q [$];

  int err_cnt;
  int n_draws;
  int n_loads;
  int n_cfg;
  int n_results;

  int          burst_left;
  int          gap_max;
  logic [15:0] ready_mask;
  logic [3:0]  rx_phase;
  int          hold_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("rolling_wave_pixel_generator_top_tb: errors");
    $finish;
  end

  // output side: stall on a rotating mask, or hold off for a counted stretch
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_ch.ready <= ready_mask[rx_phase];
        rx_phase = rx_phase + 4'd1;
      end
    end
  end

  function automatic int unsigned eff_plen();
    int unsigned n;
    n = plen_m;
    if (n == 0) begin
      n = 1;
    end else if (n > PATTERN_DEPTH) begin
      n = PATTERN_DEPTH;
    end
    return n;
  endfunction

  function automatic int unsigned dim_comp(input int unsigned c, input int unsigned ratio);
    return ((c & 32'hFF) * (1 + ratio)) >> 8;
  endfunction

  function automatic rwpg_pix_t shade_pixel(input logic [PIX_W-1:0] pix);
    int unsigned lim;
    int unsigned pos;
    int unsigned s;
    int unsigned half;
    int unsigned first;
    int unsigned adj;
    int unsigned mid;
    int unsigned st;
    int unsigned ratio;
    int unsigned wave;
    int unsigned color;
    rwpg_pix_t   p;
    lim   = grad_m + spacing_m;
    color = bg_m;
    if (lim != 0) begin
      pos = frame_cyc + pix;
      s   = pos % lim;
      if (s < grad_m) begin
        wave = palette[(pos / lim) % eff_plen()];
        if (trail_m == TRAIL_END) begin
          half = grad_m; first = 0; adj = 0; mid = 0;
        end else if (trail_m == TRAIL_LEAD) begin
          half = grad_m; first = grad_m; adj = 0; mid = grad_m - 1;
        end else begin
          half = grad_m / 2; first = half; adj = grad_m & 1; mid = half;
        end
        if (s < first) begin
          st = half - s;
        end else begin
          st = half + adj + s - grad_m;
        end
        if (s == mid) begin
          color = wave;
        end else begin
          ratio = dim_m - (st * dim_m) / (half + 1);
          color = (dim_comp(wave >> 16, ratio) << 16) |
                  (dim_comp(wave >> 8, ratio) << 8) | dim_comp(wave, ratio);
        end
      end
    end
    p.index = pix;
    p.red   = CH_W'(color >> 16);
    p.green = CH_W'(color >> 8);
    p.blue  = CH_W'(color);
    return p;
  endfunction

  task automatic render_pixel(input logic [PIX_W-1:0] pix, input logic last);
    int unsigned total;
    pixel_q.push_back(shade_pixel(pix));
    if (last) begin
      total = eff_plen() * (grad_m + spacing_m);
      if (total == 0) begin
        frame_cyc = 0;
      end else begin
        frame_cyc = ((frame_cyc + 1) % total) & 32'h1FFF;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    if (err_cnt < 30) begin
      $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, exp_v, got_v);
    end
    err_cnt++;
  endtask

  // compare each result transaction with the oldest predicted pixel
  always @(posedge clk) begin
    rwpg_pix_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected pixel, index", 0, out_ch.out_index);
      end else begin
        e = pixel_q.pop_front();
        if (out_ch.out_index !== e.index) report_mismatch("out_index", e.index, out_ch.out_index);
        if (out_ch.red !== e.red)         report_mismatch("red", e.red, out_ch.red);
        if (out_ch.green !== e.green)     report_mismatch("green", e.green, out_ch.green);
        if (out_ch.blue !== e.blue)       report_mismatch("blue", e.blue, out_ch.blue);
      end
    end
  end

  task automatic send_txn(input logic op, input logic [PIX_W-1:0] pix, input logic last,
                          input logic [SLOT_W-1:0] slot, input logic [COLOR_W-1:0] color);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.pixel_index <= pix;
    in_ch.last_pixel  <= last;
    in_ch.entry_index <= slot;
    in_ch.entry_color <= color;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    if (op == OP_LOAD) begin
      palette[slot] = color;
      n_loads++;
    end else begin
      render_pixel(pix, last);
      n_draws++;
    end
  endtask

  task automatic draw(input logic [PIX_W-1:0] pix, input logic last);
    send_txn(OP_DRAW, pix, last, SLOT_W'($urandom), COLOR_W'($urandom));
  endtask

  task automatic load_slot(input logic [SLOT_W-1:0] slot, input logic [COLOR_W-1:0] color);
    send_txn(OP_LOAD, PIX_W'($urandom), 1'($urandom), slot, color);
  endtask

  task automatic drain_pipe();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GRAD:    grad_m    = data[7:0];
      CFG_SPACING: spacing_m = data[7:0];
      CFG_TRAIL:   trail_m   = data[1:0];
      CFG_DIM:     dim_m     = data[7:0];
      CFG_PLEN:    plen_m    = data[4:0];
      CFG_BG:      bg_m      = data[23:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic apply_cfg(input int unsigned grad, input int unsigned spc,
                           input logic [MODE_W-1:0] mode, input int unsigned dim,
                           input int unsigned plen, input logic [COLOR_W-1:0] bg);
    drain_pipe();
    write_reg(CFG_GRAD, CFG_DATA_W'(grad));
    write_reg(CFG_SPACING, CFG_DATA_W'(spc));
    write_reg(CFG_TRAIL, CFG_DATA_W'(mode));
    write_reg(CFG_DIM, CFG_DATA_W'(dim));
    write_reg(CFG_PLEN, CFG_DATA_W'(plen));
    write_reg(CFG_BG, bg);
  endtask

  task automatic pick_idling();
    case ($urandom_range(0, 3))
      0: begin gap_max = 0;  ready_mask = 16'hFFFF; end
      1: begin gap_max = 3;  ready_mask = 16'($urandom_range(1, 16'hFFFF)); end
      2: begin gap_max = 12; ready_mask = 16'hFFFF; end
      default: begin gap_max = 0; ready_mask = 16'($urandom_range(1, 16'hFFFF)); end
    endcase
  endtask

  task automatic test_palette_load();
    int i;
    gap_max    = 2;
    ready_mask = 16'hA5F3;
    for (i = 0; i < PATTERN_DEPTH; i++) begin
      case (i)
        0: load_slot(SLOT_W'(i), 24'hFFFFFF);
        1: load_slot(SLOT_W'(i), 24'h000000);
        2: load_slot(SLOT_W'(i), 24'hAAAAAA);
        3: load_slot(SLOT_W'(i), 24'h555555);
        default: load_slot(SLOT_W'(i), COLOR_W'($urandom));
      endcase
    end
  endtask

  task automatic test_directed_pixels();
    int i;
    // reset settings: head, both trails, spacing
    for (i = 0; i < 6; i++) draw(PIX_W'(i), i == 5);
    // ending trail, no dimming headroom, white background
    apply_cfg(4, 2, TRAIL_END, 0, 1, 24'hFFFFFF);
    draw(10'd0, 1'b0);
    draw(10'd1023, 1'b1);
    apply_cfg(5, 1, TRAIL_LEAD, 255, 2, 24'h000000);
    draw(10'd3, 1'b0);
    draw(10'd4, 1'b1);
    // mode 3 acts as both trails, zero length acts as one
    apply_cfg(7, 3, 2'd3, 128, 0, 24'h123456);
    draw(10'd2, 1'b0);
    draw(10'd3, 1'b1);
    // widest waves, length above the table depth
    apply_cfg(255, 255, TRAIL_BOTH, 255, 31, 24'h00FF00);
    draw(10'd1023, 1'b0);
    draw(10'd127, 1'b1);
    // zero wave and spacing: background only, count cleared
    apply_cfg(0, 0, TRAIL_BOTH, 255, 16, 24'hFF00FF);
    draw(10'd7, 1'b1);
    draw(10'd3, 1'b0);
  endtask

  task automatic test_random_frames();
    int ph;
    int cnt;
    int flen;
    int k;
    int base;
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0: apply_cfg(255, 255, MODE_W'($urandom_range(0, 3)), 255, 16, COLOR_W'($urandom));
        1: apply_cfg(1, 0, MODE_W'($urandom_range(0, 3)), 0, $urandom_range(0, 1),
                     COLOR_W'($urandom));
        2: apply_cfg($urandom_range(1, 255), $urandom_range(0, 255),
                     MODE_W'($urandom_range(0, 3)), $urandom_range(0, 255),
                     $urandom_range(0, 31), COLOR_W'($urandom));
        default: apply_cfg($urandom_range(1, 12), $urandom_range(0, 6),
                           MODE_W'($urandom_range(0, 3)), $urandom_range(0, 255),
                           $urandom_range(1, 4), COLOR_W'($urandom));
      endcase
      pick_idling();
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        k = $urandom_range(0, 9);
        if (k < 7) begin
          flen = $urandom_range(1, 32);
          base = $urandom_range(0, 1) ? $urandom_range(0, 1023) : 0;
          for (k = 0; k < flen; k++) draw(PIX_W'(base + k), k == flen - 1);
          cnt += flen;
        end else if (k == 7) begin
          load_slot(SLOT_W'($urandom), COLOR_W'($urandom));
          cnt++;
        end else begin
          draw(PIX_W'($urandom), 1'($urandom));
          cnt++;
        end
      end
    end
  endtask

  task automatic test_output_holdoff();
    int k;
    apply_cfg(6, 3, TRAIL_BOTH, 200, 3, 24'h102030);
    gap_max     = 0;
    ready_mask  = 16'hFFFF;
    hold_cycles = 300;
    for (k = 0; k < 120; k++) draw(PIX_W'(k % 40), (k % 40) == 39);
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_LOAD;
    in_ch.pixel_index = '0;
    in_ch.last_pixel  = 1'b0;
    in_ch.entry_index = '0;
    in_ch.entry_color = '0;
    grad_m     = 4;
    spacing_m  = 2;
    trail_m    = TRAIL_BOTH;
    dim_m      = 255;
    plen_m     = 1;
    bg_m       = 0;
    frame_cyc  = 0;
    err_cnt    = 0;
    n_draws    = 0;
    n_loads    = 0;
    n_cfg      = 0;
    n_results  = 0;
    burst_left = 0;
    gap_max    = 0;
    ready_mask = 16'hFFFF;
    rx_phase   = '0;
    hold_cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_palette_load();
    test_directed_pixels();
    test_random_frames();
    test_output_holdoff();
    drain_pipe();

    $display("covered %0d pixel draws and %0d palette loads, %0d pixels checked",
             n_draws, n_loads, n_results);
    $display("across %0d register writes, all trail modes, extremes and held-off output",
             n_cfg);
    if (err_cnt == 0 && pixel_q.size() == 0) begin
      $display("rolling_wave_pixel_generator_top_tb: clean");
    end else begin
      $display("rolling_wave_pixel_generator_top_tb: errors");
    end
    $finish;
  end

endmodule
